FILE: sv/ctt_pkg.sv
// shared types, constants and keyword tables for the config text tokenizer
package ctt_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;

    // keywords: server, location (block), listen, index (directive)
    localparam int KW_COUNT = 4;
    localparam int KW_BLOCK_COUNT = 2;
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd8, 4'd6, 4'd5};
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{8'h73, 8'h65, 8'h72, 8'h76, 8'h65, 8'h72, 8'h00, 8'h00},
        '{8'h6C, 8'h6F, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6F, 8'h6E},
        '{8'h6C, 8'h69, 8'h73, 8'h74, 8'h65, 8'h6E, 8'h00, 8'h00},
        '{8'h69, 8'h6E, 8'h64, 8'h65, 8'h78, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic [2:0] {
        KIND_LBRACE    = 3'd0,
        KIND_RBRACE    = 3'd1,
        KIND_SEMICOLON = 3'd2,
        KIND_BLOCK     = 3'd3,
        KIND_DIRECTIVE = 3'd4,
        KIND_VALUE     = 3'd5,
        KIND_END       = 3'd6
    } tok_kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        tok_kind_t   token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [23:0] start_offset;
        logic [7:0]  word_length;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [23:0] offset;
        logic [7:0]  length;
    } tok_t;

    typedef struct packed {
        tok_t first;
        tok_t second;
        logic two;
    } entry_t;

endpackage

FILE: sv/ctt_front.sv
// scanner: classifies each byte, tracks position and builds token entries
module ctt_front
    import ctt_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     push,
    output entry_t   push_entry
);

    localparam int LX = (LINE_BITS > 16) ? LINE_BITS : 16;
    localparam int OX = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
    localparam int NX = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_COMMENT
    } mode_t;

    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [LENGTH_BITS-1:0] len_t;

    function automatic logic [15:0] clamp_line(input line_t v);
        logic [LX-1:0] vx;
        vx = LX'(v);
        return (vx > LX'(16'hFFFF)) ? 16'hFFFF : vx[15:0];
    endfunction

    function automatic logic [23:0] clamp_off(input off_t v);
        logic [OX-1:0] vx;
        vx = OX'(v);
        return (vx > OX'(24'hFFFFFF)) ? 24'hFFFFFF : vx[23:0];
    endfunction

    function automatic logic [7:0] clamp_len(input len_t v);
        logic [NX-1:0] vx;
        vx = NX'(v);
        return (vx > NX'(8'hFF)) ? 8'hFF : vx[7:0];
    endfunction

    function automatic logic [3:0] kw_filter(input logic [3:0] cand, input len_t len,
                                             input logic [7:0] c);
        logic [3:0] r;
        r = cand;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (len >= LENGTH_BITS'(KW_LEN[k]) || KW_TEXT[k][len[2:0]] != c)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic tok_kind_t word_kind(input logic [3:0] cand, input len_t len);
        tok_kind_t r;
        r = KIND_VALUE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand[k] && len == LENGTH_BITS'(KW_LEN[k]))
            begin
                r = (k < KW_BLOCK_COUNT) ? KIND_BLOCK : KIND_DIRECTIVE;
            end
        end
        return r;
    endfunction

    mode_t      mode_reg, mode_next;
    line_t      line_reg, line_next;
    line_t      col_reg, col_next;
    off_t       off_reg, off_next;
    line_t      ws_line_reg, ws_line_next;
    line_t      ws_col_reg, ws_col_next;
    off_t       ws_off_reg, ws_off_next;
    len_t       wlen_reg, wlen_next;
    logic [3:0] cand_reg, cand_next;

    logic       accept;
    logic [7:0] c;
    logic       fin;
    logic       is_blank, is_delim, is_hash, is_lf;
    line_t      line_mv, col_mv;
    off_t       off_mv;
    len_t       base_len, tb_len;
    logic [3:0] base_cand, tb_cand;
    tok_kind_t  delim_kind;
    tok_t       word_new, word_old, delim_tok, end_tok;
    logic [1:0] ntok;
    tok_t       tok_a, tok_b;

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;
    assign c        = in_item.char_byte;
    assign fin      = in_item.is_final;

    assign is_lf    = (c == CH_LF);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || is_lf;
    assign is_delim = (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_SEMI);
    assign is_hash  = (c == CH_HASH);

    assign off_mv  = (off_reg == '1) ? off_reg : off_reg + OFFSET_BITS'(1);
    assign line_mv = !is_lf ? line_reg :
                     (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
    assign col_mv  = is_lf ? LINE_BITS'(1) :
                     (col_reg == '1) ? col_reg : col_reg + LINE_BITS'(1);

    assign base_len  = (mode_reg == MODE_WORD) ? wlen_reg : '0;
    assign base_cand = (mode_reg == MODE_WORD) ? cand_reg : 4'hF;
    assign tb_cand   = kw_filter(base_cand, base_len, c);
    assign tb_len    = (base_len == '1) ? base_len : base_len + LENGTH_BITS'(1);

    assign delim_kind = (c == CH_LBRACE) ? KIND_LBRACE :
                        (c == CH_RBRACE) ? KIND_RBRACE : KIND_SEMICOLON;

    always_comb
    begin
        word_new.kind   = word_kind(tb_cand, tb_len);
        word_new.line   = clamp_line((mode_reg == MODE_WORD) ? ws_line_reg : line_reg);
        word_new.column = clamp_line((mode_reg == MODE_WORD) ? ws_col_reg : col_reg);
        word_new.offset = clamp_off((mode_reg == MODE_WORD) ? ws_off_reg : off_reg);
        word_new.length = clamp_len(tb_len);

        word_old.kind   = word_kind(cand_reg, wlen_reg);
        word_old.line   = clamp_line(ws_line_reg);
        word_old.column = clamp_line(ws_col_reg);
        word_old.offset = clamp_off(ws_off_reg);
        word_old.length = clamp_len(wlen_reg);

        delim_tok.kind   = delim_kind;
        delim_tok.line   = clamp_line(line_reg);
        delim_tok.column = clamp_line(col_reg);
        delim_tok.offset = clamp_off(off_reg);
        delim_tok.length = 8'd1;

        end_tok.kind   = KIND_END;
        end_tok.line   = clamp_line(line_mv);
        end_tok.column = clamp_line(col_mv);
        end_tok.offset = clamp_off(off_mv);
        end_tok.length = 8'd0;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        off_next     = off_reg;
        ws_line_next = ws_line_reg;
        ws_col_next  = ws_col_reg;
        ws_off_next  = ws_off_reg;
        wlen_next    = wlen_reg;
        cand_next    = cand_reg;
        ntok         = 2'd0;
        tok_a        = delim_tok;
        tok_b        = delim_tok;

        case (mode_reg)
            MODE_COMMENT:
            begin
                line_next = line_mv;
                col_next  = col_mv;
                off_next  = off_mv;
                if (is_lf)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                if (mode_reg == MODE_WORD && !is_blank && !is_delim)
                begin
                    line_next = line_mv;
                    col_next  = col_mv;
                    off_next  = off_mv;
                    wlen_next = tb_len;
                    cand_next = tb_cand;
                    if (fin)
                    begin
                        tok_a = word_new;
                        ntok  = 2'd1;
                    end
                end
                else
                begin
                    // word ended by a blank or delimiter goes out first
                    if (mode_reg == MODE_WORD)
                    begin
                        tok_a = word_old;
                        ntok  = 2'd1;
                    end
                    if (is_blank)
                    begin
                        line_next = line_mv;
                        col_next  = col_mv;
                        off_next  = off_mv;
                        mode_next = MODE_IDLE;
                        if (fin)
                        begin
                            if (ntok == 2'd0)
                            begin
                                tok_a = end_tok;
                            end
                            else
                            begin
                                tok_b = end_tok;
                            end
                            ntok = ntok + 2'd1;
                        end
                    end
                    else if (is_delim)
                    begin
                        if (ntok == 2'd0)
                        begin
                            tok_a = delim_tok;
                        end
                        else
                        begin
                            tok_b = delim_tok;
                        end
                        ntok      = ntok + 2'd1;
                        line_next = line_mv;
                        col_next  = col_mv;
                        off_next  = off_mv;
                        mode_next = MODE_IDLE;
                    end
                    else if (is_hash)
                    begin
                        mode_next = MODE_COMMENT;
                        line_next = line_mv;
                        col_next  = col_mv;
                        off_next  = off_mv;
                    end
                    else
                    begin
                        ws_line_next = line_reg;
                        ws_col_next  = col_reg;
                        ws_off_next  = off_reg;
                        wlen_next    = tb_len;
                        cand_next    = tb_cand;
                        line_next    = line_mv;
                        col_next     = col_mv;
                        off_next     = off_mv;
                        mode_next    = MODE_WORD;
                        if (fin)
                        begin
                            tok_a = word_new;
                            ntok  = 2'd1;
                        end
                    end
                end
            end
        endcase

        // last byte of a text restarts everything
        if (fin)
        begin
            mode_next    = MODE_IDLE;
            line_next    = LINE_BITS'(1);
            col_next     = LINE_BITS'(1);
            off_next     = '0;
            ws_line_next = LINE_BITS'(1);
            ws_col_next  = LINE_BITS'(1);
            ws_off_next  = '0;
            wlen_next    = '0;
            cand_next    = 4'hF;
        end
    end

    assign push              = accept && (ntok != 2'd0);
    assign push_entry.first  = tok_a;
    assign push_entry.second = tok_b;
    assign push_entry.two    = (ntok == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            line_reg    <= LINE_BITS'(1);
            col_reg     <= LINE_BITS'(1);
            off_reg     <= '0;
            ws_line_reg <= LINE_BITS'(1);
            ws_col_reg  <= LINE_BITS'(1);
            ws_off_reg  <= '0;
            wlen_reg    <= '0;
            cand_reg    <= 4'hF;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            off_reg     <= off_next;
            ws_line_reg <= ws_line_next;
            ws_col_reg  <= ws_col_next;
            ws_off_reg  <= ws_off_next;
            wlen_reg    <= wlen_next;
            cand_reg    <= cand_next;
        end
    end

endmodule

FILE: sv/ctt_queue.sv
// short fifo of token entries between scanner and output side
module ctt_queue
    import ctt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/ctt_back.sv
// output side: splits two-token entries and holds the output register
module ctt_back
    import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  entry_t    head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      pend_valid_reg, pend_valid_next;
    tok_t      pend_reg, pend_next;
    logic      load;

    function automatic out_item_t make_item(input tok_t t, input logic last);
        out_item_t r;
        r.token_kind   = t.kind;
        r.start_line   = t.line;
        r.start_column = t.column;
        r.start_offset = t.offset;
        r.word_length  = t.length;
        r.last_of_run  = last;
        return r;
    endfunction

    assign load = !out_valid_reg || out_ready;
    assign pop  = load && !pend_valid_reg && !empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = make_item(pend_reg, 1'b1);
                pend_valid_next = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = make_item(head.first, !head.two);
                pend_valid_next = head.two;
                pend_next       = head.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        pend_reg     <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: sv/config_text_tokenizer.sv
// top level of the config text tokenizer: scanner, entry queue, output stage
//
//  channel | direction | handshake            | item
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | in_item_t: one byte of text
//  out     | output    | out_valid / out_ready| out_item_t: one token
//
// one byte is taken per cycle while in_ready is high; each token is registered in the
// entry queue, then in the output stage. a byte that yields two tokens frees its queue
// entry at once and holds its second token in the output stage, so while out_ready is
// high the output moves one token per cycle; in_ready drops only when the queue is full
// reset clears scan state, queue pointers and output valid
module config_text_tokenizer
    import ctt_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;

    ctt_front #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ctt_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    ctt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
